FILE: hw/rtl/plist_pkg.sv
// Shared types and constants for the positional list store.
// Holds the request and result payloads, status and operation codes and the sequencer states.
// Depends on nothing; every other file of the block refers to it by scoped names.
package plist_pkg;

	localparam int DEPTH_DEF = 16;

	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_REMOVE  = 2'd1,
		OP_REVERSE = 2'd2,
		OP_SHOW    = 2'd3
	} op_e;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_FULL   = 2'd3
	} status_e;

	typedef struct packed {
		op_e                operation;
		logic signed [31:0] value;
		logic [7:0]         position;
	} request_t;

	typedef struct packed {
		status_e            status;
		logic signed [31:0] entry_value;
		logic [7:0]         entry_index;
		logic               last;
	} result_t;

	typedef struct packed {
		logic    valid;
		result_t res;
	} emit_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_SHIFT,
		S_INS_WAIT,
		S_INS_PUT,
		S_REM_SHIFT,
		S_REM_DONE,
		S_REV_RA,
		S_REV_RB,
		S_REV_WA,
		S_REV_WB,
		S_SHOW,
		S_SHOW_DRAIN
	} state_e;

endpackage

FILE: hw/rtl/plist_mem.sv
// Entry storage of the positional list store: one write port and one registered read port.
// Depends on plist_pkg for its default depth; it is driven by the sequencer in plist_ctrl.
module plist_mem #(
	parameter int DEPTH = plist_pkg::DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem_q [DEPTH];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/plist_ctrl.sv
// Sequencer of the positional list store with its shared step unit and list length register.
// Depends on plist_pkg; drives the ports of plist_mem and hands results to the top level.
module plist_ctrl #(
	parameter int DEPTH = plist_pkg::DEPTH_DEF,
	localparam int AW = $clog2(DEPTH),
	localparam int LW = $clog2(DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  plist_pkg::request_t request,
	output logic                busy,
	output logic                mem_we,
	output logic [AW-1:0]       mem_waddr,
	output logic [31:0]         mem_wdata,
	output logic [AW-1:0]       mem_raddr,
	input  logic [31:0]         mem_rdata,
	output plist_pkg::emit_t    emit
);

	typedef enum logic [1:0] {
		SRC_LO,
		SRC_HI,
		SRC_LEN
	} step_src_e;

	plist_pkg::state_e  state_q, state_d;
	logic [LW-1:0]      length_q, length_d;
	logic [LW-1:0]      lo_q, lo_d;
	logic [LW-1:0]      hi_q, hi_d;
	logic [LW-1:0]      pos_q, pos_d;
	logic signed [31:0] value_q, value_d;
	logic [31:0]        tmp_q;
	logic               wv_s1;
	logic [AW-1:0]      wa_s1;
	logic               shv_s1;
	logic [LW-1:0]      shi_s1;
	step_src_e          step_src;
	logic               step_dec;
	logic [LW-1:0]      step_x;
	logic [LW-1:0]      step_y;
	logic [LW-1:0]      n_m1;
	logic [LW-1:0]      pos_m1;
	logic [8:0]         pos9;
	logic [8:0]         n9;

	function automatic plist_pkg::result_t status_result(plist_pkg::status_e st);
		plist_pkg::result_t r;
		r.status      = st;
		r.entry_value = '0;
		r.entry_index = '0;
		r.last        = 1'b1;
		return r;
	endfunction

	always_comb begin
		case (step_src)
			SRC_LO:  step_x = lo_q;
			SRC_HI:  step_x = hi_q;
			SRC_LEN: step_x = length_q;
			default: step_x = lo_q;
		endcase
		step_y = step_x + (step_dec ? {LW{1'b1}} : LW'(1));
	end

	assign n_m1   = length_q - LW'(1);
	assign pos_m1 = pos_q - LW'(1);
	assign pos9   = {1'b0, request.position};
	assign n9     = 9'(length_q);
	assign busy   = (state_q != plist_pkg::S_IDLE);

	always_comb begin
		state_d   = state_q;
		length_d  = length_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		pos_d     = pos_q;
		value_d   = value_q;
		step_src  = SRC_LO;
		step_dec  = 1'b0;
		mem_we    = wv_s1;
		mem_waddr = wa_s1;
		mem_wdata = mem_rdata;
		mem_raddr = lo_q[AW-1:0];
		emit      = '0;
		if (shv_s1) begin
			emit.valid           = 1'b1;
			emit.res.status      = plist_pkg::ST_OK;
			emit.res.entry_value = mem_rdata;
			emit.res.entry_index = 8'(shi_s1) + 8'd1;
			emit.res.last        = (state_q == plist_pkg::S_SHOW_DRAIN);
		end
		case (state_q)
			plist_pkg::S_IDLE: begin
				if (start) begin
					case (request.operation)
						plist_pkg::OP_INSERT: begin
							if (pos9 == 9'd0 || pos9 > n9 + 9'd1) begin
								emit.valid = 1'b1;
								emit.res   = status_result(plist_pkg::ST_BADPOS);
							end else if (n9 == 9'(DEPTH)) begin
								emit.valid = 1'b1;
								emit.res   = status_result(plist_pkg::ST_FULL);
							end else begin
								value_d = request.value;
								pos_d   = request.position[LW-1:0];
								lo_d    = length_q;
								state_d = (n9 >= pos9) ? plist_pkg::S_INS_SHIFT
									: plist_pkg::S_INS_PUT;
							end
						end
						plist_pkg::OP_REMOVE: begin
							if (pos9 == 9'd0) begin
								emit.valid = 1'b1;
								emit.res   = status_result(plist_pkg::ST_BADPOS);
							end else if (n9 == 9'd0) begin
								emit.valid = 1'b1;
								emit.res   = status_result(plist_pkg::ST_EMPTY);
							end else if (pos9 > n9) begin
								emit.valid = 1'b1;
								emit.res   = status_result(plist_pkg::ST_BADPOS);
							end else begin
								lo_d    = request.position[LW-1:0] - LW'(1);
								state_d = (pos9 == n9) ? plist_pkg::S_REM_DONE
									: plist_pkg::S_REM_SHIFT;
							end
						end
						plist_pkg::OP_REVERSE: begin
							if (n9 == 9'd0) begin
								emit.valid = 1'b1;
								emit.res   = status_result(plist_pkg::ST_EMPTY);
							end else if (n9 == 9'd1) begin
								emit.valid = 1'b1;
								emit.res   = status_result(plist_pkg::ST_OK);
							end else begin
								step_src = SRC_LEN;
								step_dec = 1'b1;
								lo_d     = '0;
								hi_d     = step_y;
								state_d  = plist_pkg::S_REV_RA;
							end
						end
						plist_pkg::OP_SHOW: begin
							if (n9 == 9'd0) begin
								emit.valid = 1'b1;
								emit.res   = status_result(plist_pkg::ST_EMPTY);
							end else begin
								lo_d    = '0;
								state_d = plist_pkg::S_SHOW;
							end
						end
						default: begin
						end
					endcase
				end
			end
			plist_pkg::S_INS_SHIFT: begin
				step_dec  = 1'b1;
				mem_raddr = step_y[AW-1:0];
				if (lo_q == pos_q) begin
					state_d = plist_pkg::S_INS_WAIT;
				end else begin
					lo_d = step_y;
				end
			end
			plist_pkg::S_INS_WAIT: begin
				state_d = plist_pkg::S_INS_PUT;
			end
			plist_pkg::S_INS_PUT: begin
				mem_we     = 1'b1;
				mem_waddr  = pos_m1[AW-1:0];
				mem_wdata  = value_q;
				step_src   = SRC_LEN;
				length_d   = step_y;
				emit.valid = 1'b1;
				emit.res   = status_result(plist_pkg::ST_OK);
				state_d    = plist_pkg::S_IDLE;
			end
			plist_pkg::S_REM_SHIFT: begin
				mem_raddr = step_y[AW-1:0];
				if (step_y == n_m1) begin
					state_d = plist_pkg::S_REM_DONE;
				end else begin
					lo_d = step_y;
				end
			end
			plist_pkg::S_REM_DONE: begin
				step_src   = SRC_LEN;
				step_dec   = 1'b1;
				length_d   = step_y;
				emit.valid = 1'b1;
				emit.res   = status_result(plist_pkg::ST_OK);
				state_d    = plist_pkg::S_IDLE;
			end
			plist_pkg::S_REV_RA: begin
				state_d = plist_pkg::S_REV_RB;
			end
			plist_pkg::S_REV_RB: begin
				mem_raddr = hi_q[AW-1:0];
				state_d   = plist_pkg::S_REV_WA;
			end
			plist_pkg::S_REV_WA: begin
				mem_we    = 1'b1;
				mem_waddr = lo_q[AW-1:0];
				mem_wdata = mem_rdata;
				lo_d      = step_y;
				state_d   = plist_pkg::S_REV_WB;
			end
			plist_pkg::S_REV_WB: begin
				mem_we    = 1'b1;
				mem_waddr = hi_q[AW-1:0];
				mem_wdata = tmp_q;
				step_src  = SRC_HI;
				step_dec  = 1'b1;
				hi_d      = step_y;
				if (lo_q < step_y) begin
					state_d = plist_pkg::S_REV_RA;
				end else begin
					emit.valid = 1'b1;
					emit.res   = status_result(plist_pkg::ST_OK);
					state_d    = plist_pkg::S_IDLE;
				end
			end
			plist_pkg::S_SHOW: begin
				if (lo_q == n_m1) begin
					state_d = plist_pkg::S_SHOW_DRAIN;
				end else begin
					lo_d = step_y;
				end
			end
			plist_pkg::S_SHOW_DRAIN: begin
				state_d = plist_pkg::S_IDLE;
			end
			default: begin
				state_d = plist_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= plist_pkg::S_IDLE;
			length_q <= '0;
			wv_s1    <= 1'b0;
			shv_s1   <= 1'b0;
		end else begin
			state_q  <= state_d;
			length_q <= length_d;
			wv_s1    <= (state_q == plist_pkg::S_INS_SHIFT) || (state_q == plist_pkg::S_REM_SHIFT);
			shv_s1   <= (state_q == plist_pkg::S_SHOW);
		end
	end

	always_ff @(posedge clk) begin
		lo_q    <= lo_d;
		hi_q    <= hi_d;
		pos_q   <= pos_d;
		value_q <= value_d;
		wa_s1   <= lo_q[AW-1:0];
		shi_s1  <= lo_q;
		if (state_q == plist_pkg::S_REV_RB) begin
			tmp_q <= mem_rdata;
		end
	end

endmodule

FILE: hw/rtl/positional_list_store.sv
// Top level of the positional list store: an ordered list of signed 32-bit values.
// Depends on plist_pkg, plist_mem and plist_ctrl.
//
// A request (insert, remove, reverse or show) is taken at a rising edge where start is high
// and busy is low. Every result appears on result for exactly one cycle with strobe high;
// the receiver cannot hold results back, and result.last marks the final result of a request.
// Rejected requests (bad position, empty, full) and a reverse of one entry answer in the cycle
// after acceptance without raising busy, so a new request may follow at once.
// The entries sit in a single-port-read memory, so the sequencer moves one entry per cycle
// through a shared step adder while shifting or showing; reverse swaps pairs of entries:
//   insert at p into n entries: entries p to n shift up, last first (none when appending),
//   then the value is written; remove at p: the entries after p shift down, then the length drops,
//   reverse: floor(n/2) pairs, outermost first, each by read A, read B, write A, write B,
//   show: entries delivered in order from the first, one entry per cycle.
// Reset clears the list length; stored entries need no clearing.
module positional_list_store #(
	parameter int DEPTH = plist_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  plist_pkg::request_t request,
	output logic                busy,
	output logic                strobe,
	output plist_pkg::result_t  result
);

	localparam int AW = $clog2(DEPTH);

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [31:0]        mem_wdata;
	logic [AW-1:0]      mem_raddr;
	logic [31:0]        mem_rdata;
	plist_pkg::emit_t   emit;
	logic               strobe_q;
	plist_pkg::result_t result_q;

	plist_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.request  (request),
		.busy     (busy),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata),
		.emit     (emit)
	);

	plist_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			result_q <= emit.res;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.status != plist_pkg::ST_OK |-> result.last)
		else $error("A status-only result was not marked as the last one.");

	a_error_no_entry: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.status != plist_pkg::ST_OK |->
		result.entry_value == 32'sd0 && result.entry_index == 8'd0)
		else $error("A failed request carried an entry value or index.");

	a_request_progresses: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> strobe || busy)
		else $error("An accepted request neither answered nor kept the block busy.");

	a_show_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=>
		strobe && result.entry_index == $past(result.entry_index) + 8'd1)
		else $error("Shown entries were not delivered on consecutive cycles in order.");

endmodule
